### rtl/assert_macros.svh
// shared assertion macros, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/teba_pkg.sv
`timescale 1ns / 1ps
package teba_pkg;

  localparam int unsigned STORE_DEPTH_DEFAULT = 1024;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_OP_MODE          = 3'd0;
  localparam logic [2:0] REG_FIRST_RANK       = 3'd1;
  localparam logic [2:0] REG_SIZE_D0          = 3'd2;
  localparam logic [2:0] REG_SIZE_D1          = 3'd3;
  localparam logic [2:0] REG_SIZE_D2          = 3'd4;
  localparam logic [2:0] REG_SIZE_D3          = 3'd5;
  localparam logic [2:0] REG_SECOND_RANK      = 3'd6;
  localparam logic [2:0] REG_SECOND_LAST_SIZE = 3'd7;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [1:0]  op_mode;
    logic [2:0]  first_rank;
    logic [15:0] size_d0;
    logic [15:0] size_d1;
    logic [15:0] size_d2;
    logic [15:0] size_d3;
    logic [2:0]  second_rank;
    logic [10:0] second_last_size;
  } cfg_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
  } item_t;

  typedef enum logic [3:0] {
    FPU_IDLE,
    FPU_CLASSIFY,
    FPU_ALIGN,
    FPU_SHIFT,
    FPU_ADDSUB,
    FPU_PRENORM,
    FPU_MULT,
    FPU_DIVIDE,
    FPU_NORM,
    FPU_LEFT,
    FPU_UNDER,
    FPU_PACK,
    FPU_DONE
  } fpu_state_t;

endpackage

### rtl/teba_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module teba_front #(
  parameter int unsigned STORE_DEPTH = teba_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  teba_pkg::cfg_t  cfg,
  input  logic            cfg_write,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            kind,
  input  logic [9:0]      store_index,
  input  logic [31:0]     b_value,
  input  logic [31:0]     a_value,
  output logic            push,
  output teba_pkg::item_t push_item,
  input  logic            q_full
);
  import teba_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [31:0]   store [STORE_DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [AW-1:0] row_mod;
  logic [AW:0]   row_mod_sum;
  logic          row_mod_wrap;
  logic [31:0]   element_count;
  logic [31:0]   p2;
  logic [31:0]   p3;
  logic [31:0]   p4;
  logic [31:0]   total;
  logic [15:0]   row_position;
  logic [15:0]   row_inc;
  logic [1:0]    settle;
  logic          s1_valid;
  logic          s1_last;
  logic          s1_use_store;
  logic [31:0]   s1_a;
  logic [31:0]   s1_b;
  logic          accept;
  logic          is_load;
  logic          dispatch_ew;
  logic          dispatch_row;
  logic          dispatch_scalar;
  logic          supported;
  logic          compute;
  logic          last;
  logic          wr_en;

  always_comb begin
    unique case (cfg.first_rank)
      3'd4:    total = p4;
      3'd3:    total = p3;
      3'd2:    total = p2;
      default: total = {16'd0, cfg.size_d3};
    endcase
  end

  assign dispatch_ew = (cfg.first_rank == cfg.second_rank) &&
                       !(cfg.second_rank == 3'd1 && cfg.second_last_size == 11'd1);
  assign dispatch_row = !dispatch_ew && cfg.second_rank == 3'd1 &&
                        cfg.second_last_size != 11'd1;
  assign dispatch_scalar = !dispatch_ew && cfg.second_rank == 3'd1 &&
                           cfg.second_last_size == 11'd1;
  assign supported = dispatch_ew || dispatch_row || dispatch_scalar;

  assign in_stall = (settle != 2'd0) || (s1_valid && q_full);
  assign accept   = in_valid && !in_stall;
  assign is_load  = accept && !kind;
  assign compute  = accept && kind && supported;
  assign wr_en    = is_load && ({22'd0, store_index} < 32'(STORE_DEPTH));
  assign waddr    = AW'(store_index);
  assign raddr    = dispatch_row ? row_mod : '0;
  assign last     = (element_count + 32'd1) == total;

  assign row_inc      = row_position + 16'd1;
  assign row_mod_sum  = {1'b0, row_mod} + {{AW{1'b0}}, 1'b1};
  assign row_mod_wrap = row_mod_sum == (AW+1)'(STORE_DEPTH);

  // element total products, rebuilt through the chained p2, p3 and p4 registers after a register write
  always_ff @(posedge clk) begin
    p2 <= {16'd0, cfg.size_d3} * {16'd0, cfg.size_d2};
    p3 <= p2 * {16'd0, cfg.size_d1};
    p4 <= p3 * {16'd0, cfg.size_d0};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[waddr] <= b_value;
    end
    if (compute) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle        <= 2'd3;
      element_count <= '0;
      row_position  <= '0;
      row_mod       <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        settle <= 2'd3;
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (compute) begin
        if (last) begin
          element_count <= '0;
          row_position  <= '0;
          row_mod       <= '0;
        end else begin
          element_count <= element_count + 32'd1;
          row_position  <= (row_inc == cfg.size_d3) ? 16'd0 : row_inc;
          if (row_inc == 16'd0 || row_inc == cfg.size_d3 || row_mod_wrap) begin
            row_mod <= '0;
          end else begin
            row_mod <= row_mod_sum[AW-1:0];
          end
        end
      end
      if (compute) begin
        s1_valid <= 1'b1;
      end else if (push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      s1_a         <= a_value;
      s1_b         <= b_value;
      s1_last      <= last;
      s1_use_store <= !dispatch_ew;
    end
  end

  assign push = s1_valid && !q_full;

  always_comb begin
    push_item.a    = s1_a;
    push_item.b    = s1_use_store ? rdata : s1_b;
    push_item.last = s1_last;
  end

  `ASSERT_IMPLIES(a_accept_settled, accept, settle == 2'd0, "item taken while total not settled")

endmodule

### rtl/teba_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module teba_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  teba_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output teba_pkg::item_t pop_item,
  output logic            empty
);
  import teba_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full     = count == (PW+1)'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, push, !full, "push into full queue")
  `ASSERT_IMPLIES(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

### rtl/teba_back.sv
`timescale 1ns / 1ps
module teba_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      op_mode,
  output logic            pop,
  input  teba_pkg::item_t pop_item,
  input  logic            empty,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     result_value,
  output logic            last_element
);
  import teba_pkg::*;

  function automatic logic [3:0] lead8(input logic [7:0] v);
    logic [3:0] n;
    logic       found;
    n = 4'd0;
    found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!found && !v[i]) begin
        n = n + 4'd1;
      end else begin
        found = 1'b1;
      end
    end
    return n;
  endfunction

  fpu_state_t state, state_next;

  logic [31:0]        a;
  logic [31:0]        b;
  logic               last_r;
  logic [1:0]         op;
  logic [47:0]        x;
  logic [47:0]        aligned;
  logic               stk;
  logic signed [10:0] e;
  logic               sign;
  logic [23:0]        ma;
  logic [23:0]        mb;
  logic signed [10:0] ea;
  logic signed [10:0] eb;
  logic [7:0]         dsh;
  logic               eff_sub;
  logic [24:0]        rem;
  logic [47:0]        q;
  logic [4:0]         cnt;
  logic [31:0]        res;

  logic [31:0]        b_eff;
  logic [7:0]         a_exp;
  logic [7:0]         b_exp;
  logic [7:0]         a_e1;
  logic [7:0]         b_e1;
  logic               a_nan;
  logic               b_nan;
  logic               a_inf;
  logic               b_inf;
  logic               a_zero;
  logic               b_zero;
  logic               sx;
  logic               sp;
  logic [31:0]        sp_res;
  logic               a_big;
  logic [47:0]        small_full;
  logic [47:0]        small_sh;
  logic               small_stk;
  logic [47:0]        sum;
  logic [3:0]         sh_ma;
  logic [3:0]         sh_mb;
  logic [24:0]        div_r;
  logic [47:0]        div_q;
  logic [3:0]         lz;
  logic [3:0]         lim;
  logic [3:0]         lsh;
  logic signed [10:0] em1;
  logic signed [10:0] amt;
  logic [5:0]         rsh;
  logic [47:0]        x_rsh;
  logic               rsh_stk;
  logic [7:0]         expf;
  logic               inc;
  logic [30:0]        packed_mag;
  logic               load_out;

  assign b_eff  = (op == OP_SUB) ? {~b[31], b[30:0]} : b;
  assign a_exp  = a[30:23];
  assign b_exp  = b_eff[30:23];
  assign a_e1   = (a_exp == 8'd0) ? 8'd1 : a_exp;
  assign b_e1   = (b_exp == 8'd0) ? 8'd1 : b_exp;
  assign a_nan  = (&a_exp) && (|a[22:0]);
  assign b_nan  = (&b_exp) && (|b_eff[22:0]);
  assign a_inf  = (&a_exp) && !(|a[22:0]);
  assign b_inf  = (&b_exp) && !(|b_eff[22:0]);
  assign a_zero = a[30:0] == 31'd0;
  assign b_zero = b_eff[30:0] == 31'd0;
  assign sx     = a[31] ^ b_eff[31];

  // special operands: nan, infinity and zero
  always_comb begin
    sp = 1'b1;
    sp_res = QUIET_NAN;
    if (a_nan || b_nan) begin
      sp_res = QUIET_NAN;
    end else begin
      unique case (op)
        OP_ADD, OP_SUB: begin
          if (a_inf && b_inf) begin
            sp_res = (a[31] == b_eff[31]) ? {a[31], 8'hFF, 23'd0} : QUIET_NAN;
          end else if (a_inf) begin
            sp_res = {a[31], 8'hFF, 23'd0};
          end else if (b_inf) begin
            sp_res = {b_eff[31], 8'hFF, 23'd0};
          end else if (a_zero && b_zero) begin
            sp_res = {a[31] & b_eff[31], 31'd0};
          end else begin
            sp = 1'b0;
          end
        end
        OP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            sp_res = QUIET_NAN;
          end else if (a_inf || b_inf) begin
            sp_res = {sx, 8'hFF, 23'd0};
          end else if (a_zero || b_zero) begin
            sp_res = {sx, 31'd0};
          end else begin
            sp = 1'b0;
          end
        end
        OP_DIV: begin
          if (b_zero) begin
            sp_res = a_zero ? QUIET_NAN : {sx, 8'hFF, 23'd0};
          end else if (a_inf && b_inf) begin
            sp_res = QUIET_NAN;
          end else if (a_inf) begin
            sp_res = {sx, 8'hFF, 23'd0};
          end else if (b_inf || a_zero) begin
            sp_res = {sx, 31'd0};
          end else begin
            sp = 1'b0;
          end
        end
      endcase
    end
  end

  // alignment and add or subtract
  assign a_big      = a[30:0] >= b_eff[30:0];
  assign small_full = {1'b0, mb, 23'd0};
  always_comb begin
    if (dsh >= 8'd48) begin
      small_sh  = '0;
      small_stk = |mb;
    end else begin
      small_sh  = small_full >> dsh;
      small_stk = |(small_full & ~({48{1'b1}} << dsh));
    end
  end
  assign sum = eff_sub ? (x - aligned) : (x + aligned);

  assign sh_ma = ma[23] ? 4'd0 : lead8(ma[23:16]);
  assign sh_mb = mb[23] ? 4'd0 : lead8(mb[23:16]);

  // two quotient bits per cycle
  always_comb begin
    div_r = rem;
    div_q = q;
    for (int k = 0; k < 2; k++) begin
      if (div_r >= {1'b0, mb}) begin
        div_q = {div_q[46:0], 1'b1};
        div_r = div_r - {1'b0, mb};
      end else begin
        div_q = {div_q[46:0], 1'b0};
      end
      div_r = {div_r[23:0], 1'b0};
    end
  end

  // left normalization, at most eight places a cycle
  assign lz  = lead8(x[46:39]);
  assign em1 = e - 11'sd1;
  assign lim = (e > 11'sd8) ? 4'd8 : em1[3:0];
  assign lsh = (lz < lim) ? lz : lim;

  // denormalizing right shift
  assign amt     = 11'sd1 - e;
  assign rsh     = (amt > 11'sd63) ? 6'd63 : amt[5:0];
  assign x_rsh   = x >> rsh;
  assign rsh_stk = |(x & ~({48{1'b1}} << rsh));

  // round to nearest even and pack
  assign expf       = x[46] ? e[7:0] : 8'd0;
  assign inc        = x[22] & (x[23] | (|x[21:0]) | stk);
  assign packed_mag = {expf, x[45:23]} + {30'd0, inc};

  assign load_out = (state == FPU_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FPU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      FPU_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          state_next = FPU_CLASSIFY;
        end
      end
      FPU_CLASSIFY: begin
        if (sp) begin
          state_next = FPU_DONE;
        end else if (op == OP_ADD || op == OP_SUB) begin
          state_next = FPU_ALIGN;
        end else begin
          state_next = FPU_PRENORM;
        end
      end
      FPU_ALIGN:  state_next = FPU_SHIFT;
      FPU_SHIFT:  state_next = FPU_ADDSUB;
      FPU_ADDSUB: state_next = (sum == 48'd0) ? FPU_DONE : FPU_NORM;
      FPU_PRENORM: begin
        if (ma[23] && mb[23]) begin
          state_next = (op == OP_MUL) ? FPU_MULT : FPU_DIVIDE;
        end
      end
      FPU_MULT:   state_next = FPU_NORM;
      FPU_DIVIDE: state_next = (cnt == 5'd0) ? FPU_NORM : FPU_DIVIDE;
      FPU_NORM:   state_next = FPU_LEFT;
      FPU_LEFT:   state_next = (e > 11'sd1 && !x[46]) ? FPU_LEFT : FPU_UNDER;
      FPU_UNDER:  state_next = FPU_PACK;
      FPU_PACK:   state_next = FPU_DONE;
      FPU_DONE:   state_next = load_out ? FPU_IDLE : FPU_DONE;
      default:    state_next = FPU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      FPU_IDLE: begin
        if (!empty) begin
          a      <= pop_item.a;
          b      <= pop_item.b;
          last_r <= pop_item.last;
          op     <= op_mode;
        end
      end
      FPU_CLASSIFY: begin
        res  <= sp_res;
        ma   <= {|a_exp, a[22:0]};
        mb   <= {|b_exp, b_eff[22:0]};
        ea   <= $signed({3'd0, a_e1});
        eb   <= $signed({3'd0, b_e1});
        sign <= sx;
      end
      FPU_ALIGN: begin
        x       <= a_big ? {1'b0, |a_exp, a[22:0], 23'd0} : {1'b0, |b_exp, b_eff[22:0], 23'd0};
        mb      <= a_big ? {|b_exp, b_eff[22:0]} : {|a_exp, a[22:0]};
        e       <= a_big ? $signed({3'd0, a_e1}) : $signed({3'd0, b_e1});
        dsh     <= a_big ? (a_e1 - b_e1) : (b_e1 - a_e1);
        sign    <= a_big ? a[31] : b_eff[31];
        eff_sub <= a[31] ^ b_eff[31];
      end
      FPU_SHIFT: begin
        aligned <= {small_sh[47:1], small_sh[0] | small_stk};
      end
      FPU_ADDSUB: begin
        x   <= sum;
        stk <= 1'b0;
        res <= 32'd0;
      end
      FPU_PRENORM: begin
        ma  <= ma << sh_ma;
        mb  <= mb << sh_mb;
        ea  <= ea - $signed({7'd0, sh_ma});
        eb  <= eb - $signed({7'd0, sh_mb});
        rem <= {1'b0, ma};
        q   <= '0;
        cnt <= 5'd23;
      end
      FPU_MULT: begin
        x   <= {24'd0, ma} * {24'd0, mb};
        e   <= ea + eb - 11'sd127;
        stk <= 1'b0;
      end
      FPU_DIVIDE: begin
        rem <= div_r;
        q   <= div_q;
        cnt <= cnt - 5'd1;
        x   <= div_q;
        stk <= div_r != 25'd0;
        e   <= ea - eb + 11'sd126;
      end
      FPU_NORM: begin
        if (x[47]) begin
          x   <= x >> 1;
          stk <= stk | x[0];
          e   <= e + 11'sd1;
        end
      end
      FPU_LEFT: begin
        if (e > 11'sd1 && !x[46]) begin
          x <= x << lsh;
          e <= e - $signed({7'd0, lsh});
        end
      end
      FPU_UNDER: begin
        if (e < 11'sd1) begin
          x   <= x_rsh;
          stk <= stk | rsh_stk;
          e   <= 11'sd1;
        end
      end
      FPU_PACK: begin
        if (e >= 11'sd255) begin
          res <= {sign, 8'hFF, 23'd0};
        end else begin
          res <= {sign, packed_mag};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_value <= res;
      last_element <= last_r;
    end
  end

endmodule

### rtl/tensor_elementwise_broadcast_alu_unit.sv
`timescale 1ns / 1ps
// Elementwise single-precision add, subtract, multiply or divide of a stream of
// tensor A elements against operand B, where B comes with the item (equal
// ranks), from the operand store at the position within the innermost
// dimension (row vector), or from store entry 0 (scalar); load items (kind 0)
// fill the store and give no result, and unsupported rank pairs give none.
// The front takes one item per cycle while in_stall is low into a two-entry
// queue; the back is one sequential float unit that takes one item at a time
// and sets the rate. Divide forms two quotient bits a cycle, left
// normalization shifts at most eight places a cycle, and a subnormal operand
// of multiply or divide is prenormalized eight leading zeros at a time. After
// any register write the input stalls while the element total is rebuilt
// through the chained multipliers. NaN results come out as 0x7FC00000;
// rounding is to nearest even with subnormals kept.
module tensor_elementwise_broadcast_alu_unit #(
  parameter int unsigned STORE_DEPTH = teba_pkg::STORE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [9:0]  store_index,
  input  logic [31:0] b_value,
  input  logic [31:0] a_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic        last_element
);
  import teba_pkg::*;

  cfg_t  cfg;
  logic  cfg_write;
  logic  push;
  logic  q_full;
  logic  pop;
  logic  q_empty;
  item_t push_item;
  item_t pop_item;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode          <= OP_ADD;
      cfg.first_rank       <= 3'd1;
      cfg.size_d0          <= 16'd1;
      cfg.size_d1          <= 16'd1;
      cfg.size_d2          <= 16'd1;
      cfg.size_d3          <= 16'd1;
      cfg.second_rank      <= 3'd1;
      cfg.second_last_size <= 11'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OP_MODE:          cfg.op_mode          <= cfg_data[1:0];
        REG_FIRST_RANK:       cfg.first_rank       <= cfg_data[2:0];
        REG_SIZE_D0:          cfg.size_d0          <= cfg_data;
        REG_SIZE_D1:          cfg.size_d1          <= cfg_data;
        REG_SIZE_D2:          cfg.size_d2          <= cfg_data;
        REG_SIZE_D3:          cfg.size_d3          <= cfg_data;
        REG_SECOND_RANK:      cfg.second_rank      <= cfg_data[2:0];
        REG_SECOND_LAST_SIZE: cfg.second_last_size <= cfg_data[10:0];
      endcase
    end
  end

  teba_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_write   (cfg_write),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .store_index (store_index),
    .b_value     (b_value),
    .a_value     (a_value),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  teba_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  teba_back u_back (
    .clk          (clk),
    .rst          (rst),
    .op_mode      (cfg.op_mode),
    .pop          (pop),
    .pop_item     (pop_item),
    .empty        (q_empty),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .last_element (last_element)
  );

endmodule

### test/tb_tensor_elementwise_broadcast_alu_unit.sv
`timescale 1ns / 1ps
module tb_tensor_elementwise_broadcast_alu_unit;
  import teba_pkg::*;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;
  localparam int   DEPTH        = 1024;
  localparam int   SETTLE       = 200;

  typedef enum int {DISP_ELEMENTWISE, DISP_ROW, DISP_SCALAR, DISP_UNSUPPORTED} disp_t;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } alu_result_t;

  class alu_scoreboard;
    bit [1:0]    op;
    bit [2:0]    rank_a, rank_b;
    bit [31:0]   dim0, dim1, dim2, dim3;
    bit [10:0]   b_last;
    bit [31:0]   operand_mem [DEPTH];
    bit [31:0]   elem_count;
    bit [15:0]   row_pos;
    alu_result_t pending_results[$];
    int          errors;
    int          checked;
    int          lasts;

    function new();
      op = OP_ADD; rank_a = 1; rank_b = 1;
      dim0 = 1; dim1 = 1; dim2 = 1; dim3 = 1; b_last = 1;
      elem_count = 0; row_pos = 0; errors = 0; checked = 0; lasts = 0;
      foreach (operand_mem[i]) operand_mem[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_OP_MODE:          op = data[1:0];
        REG_FIRST_RANK:       rank_a = data[2:0];
        REG_SIZE_D0:          dim0 = data;
        REG_SIZE_D1:          dim1 = data;
        REG_SIZE_D2:          dim2 = data;
        REG_SIZE_D3:          dim3 = data;
        REG_SECOND_RANK:      rank_b = data[2:0];
        REG_SECOND_LAST_SIZE: b_last = data[10:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] single_to_double(bit [31:0] f);
      bit [23:0] fr;
      int        ex;
      fr = {1'b0, f[22:0]};
      if (f[30:23] == 8'hFF) return {f[31], 11'h7FF, f[22:0], 29'h0};
      if (f[30:23] == 8'h00) begin
        if (fr == 0) return {f[31], 63'h0};
        ex = -126;
        while (!fr[23]) begin
          fr = fr << 1;
          ex--;
        end
        return {f[31], 11'(ex + 1023), fr[22:0], 29'h0};
      end
      return {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'h0};
    endfunction

    function bit [31:0] double_to_single(bit [63:0] d);
      bit        s;
      int        e, sh;
      bit [63:0] m, q, rem, half;
      s = d[63];
      if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QUIET_NAN : {s, 8'hFF, 23'h0};
      if (d[62:52] == 11'h000) return {s, 31'h0};
      e = int'(d[62:52]) - 1023 + 127;
      m = {11'h0, 1'b1, d[51:0]};
      sh = (e >= 1) ? 29 : 30 - e;
      if (sh > 60) sh = 60;
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (e >= 1) begin
        if (q[24]) begin
          q = q >> 1;
          e++;
        end
        if (e >= 255) return {s, 8'hFF, 23'h0};
        return {s, e[7:0], q[22:0]};
      end
      return {s, q[30:0]};
    endfunction

    function bit [31:0] float_op(bit [31:0] a, bit [31:0] b);
      real ra, rb, r;
      if (op == OP_DIV && b[30:0] == 0) begin
        if (a[30:0] == 0 || (a[30:23] == 8'hFF && a[22:0] != 0)) return QUIET_NAN;
        return {a[31] ^ b[31], 8'hFF, 23'h0};
      end
      ra = $bitstoreal(single_to_double(a));
      rb = $bitstoreal(single_to_double(b));
      case (op)
        OP_ADD:  r = ra + rb;
        OP_SUB:  r = ra - rb;
        OP_MUL:  r = ra * rb;
        default: r = ra / rb;
      endcase
      return double_to_single($realtobits(r));
    endfunction

    function bit [31:0] tensor_total();
      case (rank_a)
        3'd4:    return dim0 * dim1 * dim2 * dim3;
        3'd3:    return dim1 * dim2 * dim3;
        3'd2:    return dim2 * dim3;
        default: return dim3;
      endcase
    endfunction

    function void note_input(logic kind, logic [9:0] idx, logic [31:0] b, logic [31:0] a);
      bit [31:0]   operand;
      bit [15:0]   next_row;
      alu_result_t r;
      if (kind == KIND_LOAD) begin
        operand_mem[idx] = b;
        return;
      end
      if (rank_a == rank_b && !(rank_b == 1 && b_last == 1)) operand = b;
      else if (rank_b == 1 && b_last != 1) operand = operand_mem[row_pos % DEPTH];
      else if (rank_b == 1) operand = operand_mem[0];
      else return;
      r.value = float_op(a, operand);
      r.last = (elem_count + 32'd1) == tensor_total();
      pending_results.push_back(r);
      if (r.last) begin
        elem_count = 0;
        row_pos = 0;
      end else begin
        elem_count = elem_count + 1;
        next_row = row_pos + 16'd1;
        row_pos = (next_row == dim3[15:0]) ? 16'd0 : next_row;
      end
    endfunction

    function void check(logic [31:0] value, logic last);
      alu_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h last %b", $time, value, last);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (last) lasts++;
      if (value !== e.value) begin
        $display("%0t: result_value mismatch expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last_element mismatch expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [9:0]  store_index = '0;
  logic [31:0] b_value = '0;
  logic [31:0] a_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_value;
  logic        last_element;

  alu_scoreboard sb = new();
  int send_idle_pct = 21;
  int recv_stall_pct = 79;
  int cfg_count = 0;
  int item_count = 0;

  tensor_elementwise_broadcast_alu_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .store_index(store_index),
    .b_value(b_value), .a_value(a_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .last_element(last_element)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** tensor_elementwise_broadcast_alu_unit: FAILED **");
    $finish;
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check(result_value, last_element);
  end

  task automatic send_item(logic k, logic [9:0] idx, logic [31:0] b, logic [31:0] a);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    store_index <= idx;
    b_value <= b;
    a_value <= a;
    do @(posedge clk); while (in_stall);
    sb.note_input(k, idx, b, a);
    item_count++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(logic [1:0] op, int ra, int d0, int d1, int d2, int d3,
                           int rb, int bl);
    drain();
    write_reg(REG_OP_MODE, 16'(op));
    write_reg(REG_FIRST_RANK, 16'(ra));
    write_reg(REG_SIZE_D0, 16'(d0));
    write_reg(REG_SIZE_D1, 16'(d1));
    write_reg(REG_SIZE_D2, 16'(d2));
    write_reg(REG_SIZE_D3, 16'(d3));
    write_reg(REG_SECOND_RANK, 16'(rb));
    write_reg(REG_SECOND_LAST_SIZE, 16'(bl));
    cfg_count++;
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 31'h0};
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'h0};
      2: return {1'b0, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
      4: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 154)), 23'($urandom)};
      5: return {$urandom_range(0, 1) == 1, 8'($urandom_range(240, 254)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 19))
      0:       return 65535;
      1:       return $urandom_range(1, 65535);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic random_segment();
    disp_t       d;
    int          ra, rb, bl;
    logic [31:0] a, b;
    d = disp_t'($urandom_range(0, 3));
    ra = $urandom_range(1, 4);
    rb = 1;
    bl = 1;
    case (d)
      DISP_ELEMENTWISE: begin
        rb = ra;
        bl = $urandom_range(1, 1024);
        if (rb == 1 && bl == 1) bl = 1024;
      end
      DISP_ROW: bl = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(2, 1023);
      DISP_SCALAR: bl = 1;
      default: begin
        rb = $urandom_range(2, 4);
        if (ra == rb) ra = (rb == 4) ? 2 : rb + 1;
        bl = $urandom_range(1, 1024);
      end
    endcase
    apply_cfg(2'($urandom_range(0, 3)), ra, rand_dim(), rand_dim(), rand_dim(),
              ($urandom_range(0, 9) == 0) ? $urandom_range(1025, 3000) : rand_dim(), rb, bl);
    repeat (54) begin
      b = rand_float();
      a = ($urandom_range(0, 7) == 0) ? (b ^ 32'($urandom_range(0, 255))) : rand_float();
      if ($urandom_range(0, 99) < 15) send_item(KIND_LOAD, 10'($urandom), b, a);
      else send_item(KIND_COMPUTE, 10'($urandom), b, a);
    end
  endtask

  initial begin
    logic [31:0] a_dir[5];
    logic [31:0] b_dir[5];
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int i = 0; i < DEPTH; i++) send_item(KIND_LOAD, 10'(i), $urandom, $urandom);

    a_dir = '{32'h0000_0000, 32'h3F80_0000, 32'h7F80_0000, 32'h7FC0_0001, 32'h8000_0001};
    b_dir = '{32'h8000_0000, 32'h0000_0000, 32'hFF80_0000, 32'h3F80_0000, 32'h7F7F_FFFF};
    for (int op = 0; op < 4; op++) begin
      apply_cfg(2'(op), 1, 1, 1, 1, 3, 1, 2 + op);
      for (int i = 0; i < 5; i++) send_item(KIND_COMPUTE, 10'h3FF, b_dir[i], a_dir[i]);
    end
    apply_cfg(OP_DIV, 4, 65535, 65535, 65535, 65535, 4, 1024);
    send_item(KIND_COMPUTE, 10'h000, 32'h8000_0000, 32'hBF80_0000);
    send_item(KIND_COMPUTE, 10'h000, 32'h0000_0000, 32'h7F80_0000);
    apply_cfg(OP_MUL, 1, 1, 1, 1, 1, 1, 1);
    send_item(KIND_LOAD, 10'h000, 32'h4000_0000, 32'h0);
    send_item(KIND_COMPUTE, 10'h3FF, 32'hFFFF_FFFF, 32'h0080_0000);

    for (int seg = 0; seg < 18; seg++) begin
      send_idle_pct = (seg < 6) ? 21 : (seg < 12) ? 79 : 0;
      recv_stall_pct = (seg < 6) ? 79 : (seg < 12) ? 21 : 0;
      random_segment();
    end

    drain();
    $display("%0d items sent over %0d register settings", item_count, cfg_count);
    $display("%0d results checked, %0d tensor ends seen", sb.checked, sb.lasts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** tensor_elementwise_broadcast_alu_unit: PASSED **");
    end else begin
      $display("** tensor_elementwise_broadcast_alu_unit: FAILED **");
    end
    $finish;
  end
endmodule
